/* design/tfsc_pkg.sv */
package tfsc_pkg;

   localparam int NumTypes = 5;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] status_type;
   typedef logic [2:0] ftype_type;
   typedef logic [5:0] bidx_type;

   // per-byte status codes
   localparam status_type STATUS_SKIP = 2'd0;
   localparam status_type STATUS_BODY = 2'd1;
   localparam status_type STATUS_GOOD = 2'd2;
   localparam status_type STATUS_BAD  = 2'd3;

   localparam byte_type HDR_CODE [NumTypes] = '{8'h8F, 8'h9F, 8'hAF, 8'hBF, 8'hCF};

   // index of the checksum byte (frame length - 1); unknown type falls back to 35 bytes
   function automatic bidx_type last_index(input ftype_type t);
      bidx_type idx;
      case (t)
         3'd0: idx = 6'd34;
         3'd1: idx = 6'd33;
         3'd2: idx = 6'd30;
         3'd3: idx = 6'd13;
         3'd4: idx = 6'd26;
         default: idx = 6'd34;
      endcase
      return idx;
   endfunction

   typedef struct packed {
      logic      hit;
      ftype_type ftype;
   } hdr_match_type;

   typedef struct packed {
      status_type status;
      ftype_type  frame_type;
      bidx_type   byte_index;
      byte_type   byte_value;
   } rsp_type;

endpackage

/* design/tfsc_if.sv */
interface tfsc_req_if;
   import tfsc_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface tfsc_rsp_if;
   import tfsc_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   ftype_type  frame_type;
   bidx_type   byte_index;
   byte_type   byte_value;

   modport source (output valid, output status, output frame_type, output byte_index,
                   output byte_value, input ready);
   modport sink   (input valid, input status, input frame_type, input byte_index,
                   input byte_value, output ready);
endinterface

/* design/tfsc_hdr_decode.sv */
module tfsc_hdr_decode (
   input  tfsc_pkg::byte_type      data_byte,
   output tfsc_pkg::hdr_match_type match
);
   import tfsc_pkg::*;

   // header codes are distinct, first hit wins
   always_comb begin
      match = '0;
      for (int t = 0; t < NumTypes; t++) begin
         if (!match.hit && data_byte == HDR_CODE[t]) begin
            match.hit   = 1'b1;
            match.ftype = ftype_type'(t);
         end
      end
   end

endmodule

/* design/tfsc_frame_ctrl.sv */
module tfsc_frame_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  tfsc_pkg::byte_type data_byte,
   output tfsc_pkg::rsp_type  result
);
   import tfsc_pkg::*;

   hdr_match_type hdr;

   logic      in_frame_ff, in_frame_in;
   ftype_type type_ff, type_in;
   bidx_type  pos_ff, pos_in;
   byte_type  sum_ff, sum_in;

   tfsc_hdr_decode u_hdr (
      .data_byte (data_byte),
      .match     (hdr)
   );

   always_comb begin
      in_frame_in       = in_frame_ff;
      type_in           = type_ff;
      pos_in            = pos_ff;
      sum_in            = sum_ff;
      result.status     = STATUS_SKIP;
      result.frame_type = '0;
      result.byte_index = '0;
      result.byte_value = data_byte;

      if (!in_frame_ff) begin
         if (hdr.hit) begin
            in_frame_in       = 1'b1;
            type_in           = hdr.ftype;
            pos_in            = 6'd1;
            sum_in            = data_byte;
            result.status     = STATUS_BODY;
            result.frame_type = hdr.ftype;
         end
      end else begin
         result.frame_type = type_ff;
         result.byte_index = pos_ff;
         if (pos_ff >= last_index(type_ff)) begin
            // checksum byte: compare, then back to hunting
            result.status = (sum_ff == data_byte) ? STATUS_GOOD : STATUS_BAD;
            in_frame_in   = 1'b0;
            type_in       = '0;
            pos_in        = '0;
            sum_in        = '0;
         end else begin
            result.status = STATUS_BODY;
            sum_in        = sum_ff + data_byte;
            pos_in        = pos_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         type_ff     <= '0;
         pos_ff      <= '0;
         sum_ff      <= '0;
      end else if (step) begin
         in_frame_ff <= in_frame_in;
         type_ff     <= type_in;
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

/* design/typed_frame_sum_checker_unit.sv */
// Channel   Dir   Role    Payload
// req_if    in    sink    data_byte[7:0]
// rsp_if    out   source  status[1:0] frame_type[2:0] byte_index[5:0] byte_value[7:0]
//
// One transaction in, one transaction out, one per cycle sustained while rsp_if is ready.
// The path runs through the input register, then frame logic into the result register.
// The frame state (type, position, running sum) updates when a byte moves from the
// input register into the result register, so a byte's status never waits on the next.
// Reset is synchronous; it clears both valid flags and the frame state (hunting).
// A stalled rsp_if holds the result; req_if stays ready while the input register
// is empty or can move forward in the same cycle.
module typed_frame_sum_checker_unit (
   input logic       clock,
   input logic       reset,
   tfsc_req_if.sink   req_if,
   tfsc_rsp_if.source rsp_if
);
   import tfsc_pkg::*;

   // input register
   logic     s1_valid_ff, s1_valid_in;
   byte_type s1_byte_ff;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff;

   rsp_type result;
   logic    out_free;   // result register empty or draining this cycle
   logic    s1_adv;     // byte moves from input register to result register
   logic    req_take;

   assign out_free = !out_valid_ff || rsp_if.ready;
   assign s1_adv   = s1_valid_ff && out_free;

   assign req_if.ready = !s1_valid_ff || out_free;
   assign req_take     = req_if.valid && req_if.ready;

   assign s1_valid_in  = req_if.ready ? req_if.valid : s1_valid_ff;
   assign out_valid_in = out_free ? s1_valid_ff : out_valid_ff;

   tfsc_frame_ctrl u_frame (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_adv),
      .data_byte (s1_byte_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_if.data_byte;
      end
      if (s1_adv) begin
         out_rsp_ff <= result;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.status     = out_rsp_ff.status;
   assign rsp_if.frame_type = out_rsp_ff.frame_type;
   assign rsp_if.byte_index = out_rsp_ff.byte_index;
   assign rsp_if.byte_value = out_rsp_ff.byte_value;

endmodule

/* design/tfsc_checker.sv */
module tfsc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input tfsc_pkg::status_type status,
   input tfsc_pkg::ftype_type  frame_type,
   input tfsc_pkg::bidx_type   byte_index,
   input tfsc_pkg::byte_type   byte_value
);
   import tfsc_pkg::*;

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(frame_type)
         && $stable(byte_index) && $stable(byte_value))
      else $error("stalled result changed");

   // skipped bytes carry no frame info
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_SKIP |-> frame_type == 3'd0 && byte_index == 6'd0)
      else $error("skipped byte with frame fields set");

   // header byte of a frame matches its reported type
   a_hdr_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_BODY && byte_index == 6'd0
         |-> byte_value[3:0] == 4'hF && byte_value[7:4] == 4'(frame_type) + 4'd8
         && frame_type <= 3'd4)
      else $error("frame header does not match frame type");

endmodule

bind typed_frame_sum_checker_unit tfsc_checker u_tfsc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .status     (rsp_if.status),
   .frame_type (rsp_if.frame_type),
   .byte_index (rsp_if.byte_index),
   .byte_value (rsp_if.byte_value)
);
